// ----- rtl/talu_pkg.sv -----
// Shared types and opcode codes for the Thumb ALU with flags.
`default_nettype none

package talu_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [4:0] {
        OP_ADC    = 5'd0,
        OP_ADDS   = 5'd1,
        OP_ADD    = 5'd2,
        OP_ADD4   = 5'd3,
        OP_ADDPC  = 5'd4,
        OP_AND    = 5'd5,
        OP_ASR    = 5'd6,
        OP_BIC    = 5'd7,
        OP_CMN    = 5'd8,
        OP_CMP    = 5'd9,
        OP_MOV    = 5'd10,
        OP_EOR    = 5'd11,
        OP_LSL    = 5'd12,
        OP_LSR    = 5'd13,
        OP_MOVS   = 5'd14,
        OP_MUL    = 5'd15,
        OP_MVN    = 5'd16,
        OP_NEG    = 5'd17,
        OP_ORR    = 5'd18,
        OP_REV    = 5'd19,
        OP_REV16  = 5'd20,
        OP_REVSH  = 5'd21,
        OP_ROR    = 5'd22,
        OP_SBC    = 5'd23,
        OP_SUBS   = 5'd24,
        OP_SUB4   = 5'd25,
        OP_TST    = 5'd26,
        OP_UXTB   = 5'd27,
        OP_UXTH   = 5'd28,
        OP_SXTB   = 5'd29,
        OP_SXTH   = 5'd30
    } op_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [4:0]        opcode;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [3:0]        dest_reg;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              write_result;
        logic [3:0]        dest_reg_out;
        logic              flag_n;
        logic              flag_z;
        logic              flag_c;
        logic              flag_v;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/thumb_alu_with_flags_top.sv -----
// Top level of the Thumb ALU: input register, one execute pass, result register.
// An accepted item is held in the input register, then moves into the result register, which raises m_valid.
// Throughput: one item per cycle while m_ready is high; the single pass holds the 32x32 multiply and the adder.
// The NZCV flags update as an item moves into the result register, so the next item sees them.
// Reset (aresetn low, synchronous) empties both stages and clears all four flags.
`default_nettype none

module thumb_alu_with_flags_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire talu_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output talu_pkg::out_item_t       m_data
);

    talu_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    talu_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    talu_pkg::flags_t    flags_reg;
    talu_pkg::flags_t    flags_next;
    talu_pkg::out_item_t out_next;
    logic                adv_out;

    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  n8;
    talu_pkg::op_t op;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] add_sum;
    logic        add_v;
    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic signed [32:0] asr_w;
    logic [63:0] ror_w;
    logic [31:0] mul_r;
    logic [31:0] b_x4;
    logic [31:0] res;
    logic        wr;
    logic        c_new;
    logic        set_nz;
    logic        set_c;
    logic        set_v;

    assign adv_out = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv_out;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign a    = in_reg.operand_a;
    assign b    = in_reg.operand_b;
    assign n8   = b[7:0];
    assign op   = talu_pkg::op_t'(in_reg.opcode);
    assign b_x4 = {b[29:0], 2'b00};

    // Shared adder: subtract forms feed ~b with carry in
    always_comb begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        unique case (op)
            talu_pkg::OP_ADC: add_cin = flags_reg.c;
            talu_pkg::OP_CMP, talu_pkg::OP_SUBS: begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            talu_pkg::OP_SBC: begin
                add_y   = ~b;
                add_cin = flags_reg.c;
            end
            talu_pkg::OP_NEG: begin
                add_x   = '0;
                add_y   = ~b;
                add_cin = 1'b1;
            end
            default: begin
                add_x   = a;
                add_y   = b;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v   = (~(add_x[31] ^ add_y[31])) & (add_x[31] ^ add_sum[31]);

    // Extra bit on each of LSL, LSR and ASR catches the last bit shifted out
    assign lsl_w = {1'b0, a} << n8;
    assign lsr_w = {a, 1'b0} >> n8;
    assign asr_w = $signed({a, 1'b0}) >>> n8;
    assign ror_w = {a, a} >> n8[4:0];
    assign mul_r = a * b;

    always_comb begin
        res    = '0;
        wr     = 1'b1;
        c_new  = flags_reg.c;
        set_nz = 1'b0;
        set_c  = 1'b0;
        set_v  = 1'b0;
        unique case (op)
            talu_pkg::OP_ADC, talu_pkg::OP_ADDS, talu_pkg::OP_NEG,
            talu_pkg::OP_SBC, talu_pkg::OP_SUBS: begin
                res    = add_sum[31:0];
                c_new  = add_sum[32];
                set_nz = 1'b1;
                set_c  = 1'b1;
                set_v  = 1'b1;
            end
            talu_pkg::OP_CMN, talu_pkg::OP_CMP: begin
                res    = add_sum[31:0];
                wr     = 1'b0;
                c_new  = add_sum[32];
                set_nz = 1'b1;
                set_c  = 1'b1;
                set_v  = 1'b1;
            end
            talu_pkg::OP_ADD:   res = a + b;
            talu_pkg::OP_ADD4:  res = a + b_x4;
            talu_pkg::OP_ADDPC: res = {a[31:2], 2'b00} + b_x4;
            talu_pkg::OP_SUB4:  res = a - b_x4;
            talu_pkg::OP_AND: begin
                res    = a & b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_TST: begin
                res    = a & b;
                wr     = 1'b0;
                set_nz = 1'b1;
            end
            talu_pkg::OP_BIC: begin
                res    = a & ~b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_EOR: begin
                res    = a ^ b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_ORR: begin
                res    = a | b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_MOVS: begin
                res    = b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_MVN: begin
                res    = ~b;
                set_nz = 1'b1;
            end
            talu_pkg::OP_MUL: begin
                res    = mul_r;
                set_nz = 1'b1;
            end
            talu_pkg::OP_MOV: res = b;
            // Shifts by zero pass a through and hold C
            talu_pkg::OP_LSL: begin
                res    = (n8 == 8'd0) ? a : lsl_w[31:0];
                c_new  = (n8 == 8'd0) ? flags_reg.c : lsl_w[32];
                set_nz = 1'b1;
                set_c  = 1'b1;
            end
            talu_pkg::OP_LSR: begin
                res    = (n8 == 8'd0) ? a : lsr_w[32:1];
                c_new  = (n8 == 8'd0) ? flags_reg.c : lsr_w[0];
                set_nz = 1'b1;
                set_c  = 1'b1;
            end
            talu_pkg::OP_ASR: begin
                res    = (n8 == 8'd0) ? a : asr_w[32:1];
                c_new  = (n8 == 8'd0) ? flags_reg.c : asr_w[0];
                set_nz = 1'b1;
                set_c  = 1'b1;
            end
            talu_pkg::OP_ROR: begin
                res    = ror_w[31:0];
                c_new  = (n8 == 8'd0) ? flags_reg.c : ror_w[31];
                set_nz = 1'b1;
                set_c  = 1'b1;
            end
            talu_pkg::OP_REV:   res = {b[7:0], b[15:8], b[23:16], b[31:24]};
            talu_pkg::OP_REV16: res = {b[23:16], b[31:24], b[7:0], b[15:8]};
            talu_pkg::OP_REVSH: res = {{16{b[7]}}, b[7:0], b[15:8]};
            talu_pkg::OP_UXTB:  res = {24'd0, b[7:0]};
            talu_pkg::OP_UXTH:  res = {16'd0, b[15:0]};
            talu_pkg::OP_SXTB:  res = {{24{b[7]}}, b[7:0]};
            talu_pkg::OP_SXTH:  res = {{16{b[15]}}, b[15:0]};
            default: begin
                res = '0;
                wr  = 1'b0;
            end
        endcase
    end

    always_comb begin
        flags_next = flags_reg;
        if (set_nz) begin
            flags_next.n = res[31];
            flags_next.z = (res == 32'd0);
        end
        if (set_c) begin
            flags_next.c = c_new;
        end
        if (set_v) begin
            flags_next.v = add_v;
        end
    end

    always_comb begin
        out_next.result       = res;
        out_next.write_result = wr;
        out_next.dest_reg_out = in_reg.dest_reg;
        out_next.flag_n       = flags_next.n;
        out_next.flag_z       = flags_next.z;
        out_next.flag_c       = flags_next.c;
        out_next.flag_v       = flags_next.v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            // Commit flags as the item moves into the result register
            if (adv_out && in_valid_reg) begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (adv_out && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.flag_n == flags_reg.n) && (out_reg.flag_z == flags_reg.z)
                       && (out_reg.flag_c == flags_reg.c) && (out_reg.flag_v == flags_reg.v))
        else $error("held result flags differ from kept flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled while a stage is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_out && in_valid_reg) |=> out_valid_reg)
        else $error("item lost between input and result register");

endmodule

`default_nettype wire

// ----- tb/thumb_alu_with_flags_top_tb.sv -----
// Testbench for the Thumb ALU: directed corner items, then random items under three idle mixes.
`timescale 1ns / 1ps

module thumb_alu_with_flags_top_tb;

    localparam int unsigned ITEMS_PER_PHASE = 605;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned TAIL_CYCLES     = 4;
    localparam logic [4:0]  OP_UNUSED       = 5'd31;

    class alu_scoreboard;
        talu_pkg::flags_t    kept_flags;
        talu_pkg::out_item_t pending_writebacks[$];
        int unsigned         mismatches;

        function new();
            kept_flags = '0;
            mismatches = 0;
        endfunction

        function logic [31:0] add_with_carry(logic [31:0] x, logic [31:0] y, logic cin,
                                             output logic cout, output logic ovf);
            logic [32:0] sum;
            sum  = {1'b0, x} + {1'b0, y} + {32'd0, cin};
            cout = sum[32];
            ovf  = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
            return sum[31:0];
        endfunction

        // Execute one instruction against the kept flags and return the write-back.
        function talu_pkg::out_item_t execute_thumb_op(talu_pkg::in_item_t item);
            talu_pkg::out_item_t wb;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            logic [7:0]  amt;
            logic [4:0]  rot;
            logic        c;
            logic        v;
            logic        wr;
            int          grp;
            a   = item.operand_a;
            b   = item.operand_b;
            amt = b[7:0];
            c   = kept_flags.c;
            v   = kept_flags.v;
            r   = '0;
            wr  = 1'b1;
            grp = 0;
            case (item.opcode)
                talu_pkg::OP_ADC: begin
                    r = add_with_carry(a, b, kept_flags.c, c, v);
                    grp = 3;
                end
                talu_pkg::OP_ADDS: begin
                    r = add_with_carry(a, b, 1'b0, c, v);
                    grp = 3;
                end
                talu_pkg::OP_ADD:   r = a + b;
                talu_pkg::OP_ADD4:  r = a + (b << 2);
                talu_pkg::OP_ADDPC: r = {a[31:2], 2'b00} + (b << 2);
                talu_pkg::OP_AND: begin
                    r = a & b;
                    grp = 1;
                end
                talu_pkg::OP_ASR: begin
                    grp = 2;
                    if (amt == 0) begin
                        r = a;
                    end else if (amt < 32) begin
                        c = a[amt - 1];
                        r = $signed(a) >>> amt;
                    end else begin
                        c = a[31];
                        r = {32{a[31]}};
                    end
                end
                talu_pkg::OP_BIC: begin
                    r = a & ~b;
                    grp = 1;
                end
                talu_pkg::OP_CMN: begin
                    r = add_with_carry(a, b, 1'b0, c, v);
                    grp = 3;
                    wr = 1'b0;
                end
                talu_pkg::OP_CMP: begin
                    r = add_with_carry(a, ~b, 1'b1, c, v);
                    grp = 3;
                    wr = 1'b0;
                end
                talu_pkg::OP_MOV: r = b;
                talu_pkg::OP_EOR: begin
                    r = a ^ b;
                    grp = 1;
                end
                talu_pkg::OP_LSL: begin
                    grp = 2;
                    if (amt == 0) begin
                        r = a;
                    end else if (amt < 32) begin
                        c = a[32 - amt];
                        r = a << amt;
                    end else begin
                        c = (amt == 32) ? a[0] : 1'b0;
                        r = '0;
                    end
                end
                talu_pkg::OP_LSR: begin
                    grp = 2;
                    if (amt == 0) begin
                        r = a;
                    end else if (amt < 32) begin
                        c = a[amt - 1];
                        r = a >> amt;
                    end else begin
                        c = (amt == 32) ? a[31] : 1'b0;
                        r = '0;
                    end
                end
                talu_pkg::OP_MOVS: begin
                    r = b;
                    grp = 1;
                end
                talu_pkg::OP_MUL: begin
                    r = a * b;
                    grp = 1;
                end
                talu_pkg::OP_MVN: begin
                    r = ~b;
                    grp = 1;
                end
                talu_pkg::OP_NEG: begin
                    r = add_with_carry(32'd0, ~b, 1'b1, c, v);
                    grp = 3;
                end
                talu_pkg::OP_ORR: begin
                    r = a | b;
                    grp = 1;
                end
                talu_pkg::OP_REV:   r = {b[7:0], b[15:8], b[23:16], b[31:24]};
                talu_pkg::OP_REV16: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
                talu_pkg::OP_REVSH: r = {{16{b[7]}}, b[7:0], b[15:8]};
                talu_pkg::OP_ROR: begin
                    grp = 2;
                    if (amt == 0) begin
                        r = a;
                    end else begin
                        rot = amt[4:0];
                        r = (rot == 0) ? a : ((a >> rot) | (a << (32 - rot)));
                        c = r[31];
                    end
                end
                talu_pkg::OP_SBC: begin
                    r = add_with_carry(a, ~b, kept_flags.c, c, v);
                    grp = 3;
                end
                talu_pkg::OP_SUBS: begin
                    r = add_with_carry(a, ~b, 1'b1, c, v);
                    grp = 3;
                end
                talu_pkg::OP_SUB4: r = a - (b << 2);
                talu_pkg::OP_TST: begin
                    r = a & b;
                    grp = 1;
                    wr = 1'b0;
                end
                talu_pkg::OP_UXTB: r = {24'd0, b[7:0]};
                talu_pkg::OP_UXTH: r = {16'd0, b[15:0]};
                talu_pkg::OP_SXTB: r = {{24{b[7]}}, b[7:0]};
                talu_pkg::OP_SXTH: r = {{16{b[15]}}, b[15:0]};
                default: begin
                    r = '0;
                    wr = 1'b0;
                end
            endcase
            if (grp != 0) begin
                kept_flags.n = r[31];
                kept_flags.z = (r == 0);
                if (grp >= 2) kept_flags.c = c;
                if (grp == 3) kept_flags.v = v;
            end
            wb.result       = r;
            wb.write_result = wr;
            wb.dest_reg_out = item.dest_reg;
            wb.flag_n       = kept_flags.n;
            wb.flag_z       = kept_flags.z;
            wb.flag_c       = kept_flags.c;
            wb.flag_v       = kept_flags.v;
            return wb;
        endfunction

        function void record_issue(talu_pkg::in_item_t item);
            pending_writebacks.push_back(execute_thumb_op(item));
        endfunction

        function int unsigned pending();
            return pending_writebacks.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_writeback(talu_pkg::out_item_t got);
            talu_pkg::out_item_t want;
            if (pending_writebacks.size() == 0) begin
                $error("result item with no issued instruction: %h", got);
                mismatches++;
                return;
            end
            want = pending_writebacks.pop_front();
            compare_field("result", want.result, got.result);
            compare_field("write_result", {31'd0, want.write_result},
                          {31'd0, got.write_result});
            compare_field("dest_reg_out", {28'd0, want.dest_reg_out},
                          {28'd0, got.dest_reg_out});
            compare_field("flag_n", {31'd0, want.flag_n}, {31'd0, got.flag_n});
            compare_field("flag_z", {31'd0, want.flag_z}, {31'd0, got.flag_z});
            compare_field("flag_c", {31'd0, want.flag_c}, {31'd0, got.flag_c});
            compare_field("flag_v", {31'd0, want.flag_v}, {31'd0, got.flag_v});
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    talu_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    talu_pkg::out_item_t m_data;

    alu_scoreboard sb;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   cycle_count   = 0;

    thumb_alu_with_flags_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check each accepted result item, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_writeback(m_data);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic talu_pkg::in_item_t make_item(logic [4:0] op, logic [31:0] a,
                                                     logic [31:0] b, logic [3:0] rd);
        talu_pkg::in_item_t item;
        item.opcode    = op;
        item.operand_a = a;
        item.operand_b = b;
        item.dest_reg  = rd;
        return item;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic talu_pkg::in_item_t random_item();
        talu_pkg::in_item_t item;
        item.opcode    = ($urandom_range(99) < 2) ? OP_UNUSED : 5'($urandom_range(30));
        item.operand_a = random_word();
        item.operand_b = random_word();
        item.dest_reg  = 4'($urandom_range(15));
        // Bias shift amounts toward the interesting range around the word width.
        if ((item.opcode == talu_pkg::OP_LSL || item.opcode == talu_pkg::OP_LSR ||
             item.opcode == talu_pkg::OP_ASR || item.opcode == talu_pkg::OP_ROR) &&
            $urandom_range(1) == 1) begin
            item.operand_b[7:0] = 8'($urandom_range(40));
        end
        return item;
    endfunction

    task automatic send_item(input talu_pkg::in_item_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.record_issue(item);
    endtask

    // Hold off the sender until every issued item has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(make_item(talu_pkg::OP_ADDS,  32'hFFFF_FFFF, 32'h0000_0001, 4'd0));
        send_item(make_item(talu_pkg::OP_ADC,   32'h0000_0000, 32'h0000_0000, 4'd15));
        send_item(make_item(talu_pkg::OP_ADDS,  32'h7FFF_FFFF, 32'h0000_0001, 4'd1));
        send_item(make_item(talu_pkg::OP_SUBS,  32'h0000_0005, 32'h0000_0005, 4'd2));
        send_item(make_item(talu_pkg::OP_SBC,   32'h0000_0000, 32'h0000_0001, 4'd3));
        send_item(make_item(talu_pkg::OP_CMP,   32'h8000_0000, 32'h0000_0001, 4'd4));
        send_item(make_item(talu_pkg::OP_CMN,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd5));
        send_item(make_item(talu_pkg::OP_NEG,   32'h0000_0000, 32'h0000_0000, 4'd6));
        send_item(make_item(talu_pkg::OP_NEG,   32'h0000_0000, 32'h8000_0000, 4'd7));
        send_item(make_item(talu_pkg::OP_LSL,   32'h8000_0001, 32'h0000_0100, 4'd8));
        send_item(make_item(talu_pkg::OP_LSL,   32'h8000_0001, 32'd32,        4'd9));
        send_item(make_item(talu_pkg::OP_LSL,   32'hFFFF_FFFF, 32'd33,        4'd10));
        send_item(make_item(talu_pkg::OP_LSR,   32'h8000_0000, 32'd32,        4'd11));
        send_item(make_item(talu_pkg::OP_LSR,   32'hFFFF_FFFF, 32'd31,        4'd12));
        send_item(make_item(talu_pkg::OP_ASR,   32'h8000_0000, 32'd200,       4'd13));
        send_item(make_item(talu_pkg::OP_ASR,   32'h8000_0000, 32'd1,         4'd14));
        send_item(make_item(talu_pkg::OP_ROR,   32'h0000_0001, 32'd64,        4'd0));
        send_item(make_item(talu_pkg::OP_ROR,   32'h0000_0001, 32'd1,         4'd1));
        send_item(make_item(talu_pkg::OP_REVSH, 32'h0000_0000, 32'h1234_0080, 4'd2));
        send_item(make_item(talu_pkg::OP_REV,   32'h0000_0000, 32'h1234_5678, 4'd3));
        send_item(make_item(talu_pkg::OP_REV16, 32'h0000_0000, 32'h1234_5678, 4'd4));
        send_item(make_item(talu_pkg::OP_SXTB,  32'h0000_0000, 32'hFFFF_FF80, 4'd5));
        send_item(make_item(talu_pkg::OP_SXTH,  32'h0000_0000, 32'h0000_8000, 4'd6));
        send_item(make_item(talu_pkg::OP_UXTB,  32'h0000_0000, 32'hFFFF_FFFF, 4'd7));
        send_item(make_item(talu_pkg::OP_UXTH,  32'h0000_0000, 32'hFFFF_FFFF, 4'd8));
        send_item(make_item(talu_pkg::OP_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd9));
        send_item(make_item(talu_pkg::OP_TST,   32'hAAAA_AAAA, 32'h5555_5555, 4'd10));
        send_item(make_item(talu_pkg::OP_ADDPC, 32'hFFFF_FFFF, 32'h0000_0001, 4'd11));
        send_item(make_item(talu_pkg::OP_ADD4,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd12));
        send_item(make_item(talu_pkg::OP_SUB4,  32'h0000_0000, 32'h0000_0001, 4'd13));
        send_item(make_item(talu_pkg::OP_MOVS,  32'hFFFF_FFFF, 32'h0000_0000, 4'd14));
        send_item(make_item(talu_pkg::OP_MVN,   32'h0000_0000, 32'h0000_0000, 4'd15));
        send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_item(random_item());
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/talu_pkg.sv
rtl/thumb_alu_with_flags_top.sv
tb/thumb_alu_with_flags_top_tb.sv
